// ----- sv/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EJQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: assertion failed");
`define EJQ_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("%m: assertion failed");
`else
`define EJQ_ASSERT(lbl, prop)
`define EJQ_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- sv/ejq_pkg.sv -----
// Types and constants of the joint quaternion builder.
`timescale 1ns / 1ps
`default_nettype none
package ejq_pkg;

	localparam int TRIG_W = 34;

	localparam logic [2:0] KIND_POS_X = 3'd0;
	localparam logic [2:0] KIND_POS_Y = 3'd1;
	localparam logic [2:0] KIND_POS_Z = 3'd2;
	localparam logic [2:0] KIND_ROT_X = 3'd3;
	localparam logic [2:0] KIND_ROT_Y = 3'd4;
	localparam logic [2:0] KIND_ROT_Z = 3'd5;
	localparam logic [2:0] KIND_NONE  = 3'd6;

	localparam logic [1:0] QI_W = 2'd0;
	localparam logic [1:0] QI_X = 2'd1;
	localparam logic [1:0] QI_Y = 2'd2;
	localparam logic [1:0] QI_Z = 2'd3;

	typedef logic [3:0][31:0] quat_t;

	typedef enum logic [1:0] {ST_IDLE, ST_TRIG, ST_QMUL, ST_EMIT} state_t;
	typedef enum logic [2:0] {TP_IDLE, TP_MOD, TP_DIV, TP_FOLD, TP_CORD} trig_phase_t;

	typedef struct packed {
		logic [1:0] qi;
		logic       use_s;
		logic       neg;
	} term_t;

	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	// Operand pick for product k of the right multiply by an axis rotation.
	function automatic term_t term_sel(input logic [1:0] axis, input logic [2:0] k);
		term_t t;
		t = '{qi: QI_W, use_s: 1'b0, neg: 1'b0};
		unique case ({axis, k})
			5'b00_000: t = '{QI_W, 1'b0, 1'b0};
			5'b00_001: t = '{QI_X, 1'b1, 1'b1};
			5'b00_010: t = '{QI_W, 1'b1, 1'b0};
			5'b00_011: t = '{QI_X, 1'b0, 1'b0};
			5'b00_100: t = '{QI_Y, 1'b0, 1'b0};
			5'b00_101: t = '{QI_Z, 1'b1, 1'b0};
			5'b00_110: t = '{QI_Z, 1'b0, 1'b0};
			5'b00_111: t = '{QI_Y, 1'b1, 1'b1};
			5'b01_000: t = '{QI_W, 1'b0, 1'b0};
			5'b01_001: t = '{QI_Y, 1'b1, 1'b1};
			5'b01_010: t = '{QI_X, 1'b0, 1'b0};
			5'b01_011: t = '{QI_Z, 1'b1, 1'b1};
			5'b01_100: t = '{QI_W, 1'b1, 1'b0};
			5'b01_101: t = '{QI_Y, 1'b0, 1'b0};
			5'b01_110: t = '{QI_Z, 1'b0, 1'b0};
			5'b01_111: t = '{QI_X, 1'b1, 1'b0};
			5'b10_000: t = '{QI_W, 1'b0, 1'b0};
			5'b10_001: t = '{QI_Z, 1'b1, 1'b1};
			5'b10_010: t = '{QI_X, 1'b0, 1'b0};
			5'b10_011: t = '{QI_Y, 1'b1, 1'b0};
			5'b10_100: t = '{QI_Y, 1'b0, 1'b0};
			5'b10_101: t = '{QI_X, 1'b1, 1'b1};
			5'b10_110: t = '{QI_W, 1'b1, 1'b0};
			5'b10_111: t = '{QI_Z, 1'b0, 1'b0};
			default:   t = '{QI_W, 1'b0, 1'b0};
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

// ----- sv/ejq_trig.sv -----
// Half-angle cosine and sine: serial modulo, serial divide by 720, CORDIC.
`timescale 1ns / 1ps
`default_nettype none
module ejq_trig import ejq_pkg::*; #(
	parameter int VALUE_FRAC_BITS = 16,
	parameter int QUAT_FRAC_BITS = 30,
	parameter int TRIG_ITERATIONS = 24
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [31:0]       deg,
	output logic                          done,
	output logic signed [TRIG_W-1:0]      cos_o,
	output logic signed [TRIG_W-1:0]      sin_o
);
	localparam int MW = 10 + VALUE_FRAC_BITS;
	localparam int DW = MW + 31;
	localparam int NW = MW + 32 - VALUE_FRAC_BITS;
	localparam int NIT = (TRIG_ITERATIONS < 31) ? TRIG_ITERATIONS : 31;
	localparam logic [63:0] MOD_L = 64'd720 << VALUE_FRAC_BITS;
	localparam logic [MW-1:0] MOD_M = MOD_L[MW-1:0];
	localparam logic signed [TRIG_W-1:0] X0 =
		TRIG_W'(64'sd652032874 >>> (30 - QUAT_FRAC_BITS));

	trig_phase_t ph_q, ph_d;
	logic [DW-1:0] r_q, d_q;
	logic [5:0] cnt_q;
	logic sgn_q, neg_q;
	logic [NW-1:0] n_q;
	logic [9:0] rem_q;
	logic [31:0] quo_q;
	logic [4:0] it_q;
	logic signed [TRIG_W-1:0] x_q, y_q, z_q;

	logic [DW-1:0] r_nx;
	logic [MW-1:0] r_lo, t_red;
	logic [10:0] rr;
	logic rr_ge;
	logic signed [TRIG_W-1:0] atn, xs, ys;
	logic [31:0] deg_abs;

	assign deg_abs = deg[31] ? 32'(-deg) : 32'(deg);
	assign r_nx = (r_q >= d_q) ? r_q - d_q : r_q;
	assign r_lo = r_nx[MW-1:0];
	assign t_red = (sgn_q && (r_lo != '0)) ? MOD_M - r_lo : r_lo;
	assign rr = {rem_q, n_q[NW-1]};
	assign rr_ge = rr >= 11'd720;
	assign atn = TRIG_W'(ATAN_TURNS[it_q]);
	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;

	always_comb begin
		ph_d = ph_q;
		unique case (ph_q)
			TP_IDLE: if (start) ph_d = TP_MOD;
			TP_MOD:  if (cnt_q == '0) ph_d = TP_DIV;
			TP_DIV:  if (cnt_q == '0) ph_d = TP_FOLD;
			TP_FOLD: ph_d = TP_CORD;
			TP_CORD: if (it_q == 5'(NIT - 1)) ph_d = TP_IDLE;
			default: ph_d = TP_IDLE;
		endcase
	end

	always_comb begin
		done = (ph_q == TP_CORD) && (it_q == 5'(NIT - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= TP_IDLE;
		end else begin
			ph_q <= ph_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (ph_q)
			TP_IDLE: begin
				r_q <= DW'(deg_abs);
				d_q <= {MOD_M, 31'b0};
				sgn_q <= deg[31];
				cnt_q <= 6'd31;
			end
			TP_MOD: begin
				r_q <= r_nx;
				d_q <= d_q >> 1;
				if (cnt_q == '0) begin
					cnt_q <= 6'(NW - 1);
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
			TP_DIV: begin
				rem_q <= rr_ge ? 10'(rr - 11'd720) : rr[9:0];
				quo_q <= {quo_q[30:0], rr_ge};
				n_q <= n_q << 1;
				cnt_q <= cnt_q - 6'd1;
			end
			TP_FOLD: begin
				x_q <= X0;
				y_q <= '0;
				it_q <= '0;
				if (quo_q < 32'h4000_0000) begin
					z_q <= TRIG_W'(quo_q);
					neg_q <= 1'b0;
				end else if (quo_q >= 32'hC000_0000) begin
					z_q <= TRIG_W'(quo_q) - (TRIG_W'(1) << 32);
					neg_q <= 1'b0;
				end else begin
					z_q <= TRIG_W'(quo_q) - (TRIG_W'(1) << 31);
					neg_q <= 1'b1;
				end
			end
			TP_CORD: begin
				it_q <= it_q + 5'd1;
				if (!z_q[TRIG_W-1]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atn;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atn;
				end
			end
			default: begin
			end
		endcase
		if (ph_q == TP_MOD && cnt_q == '0) begin
			rem_q <= '0;
			quo_q <= '0;
		end
		if (ph_q == TP_MOD) begin
			n_q <= {t_red, (32 - VALUE_FRAC_BITS)'(0)};
		end
	end

	// Last iteration result, sign applied for the folded half.
	logic signed [TRIG_W-1:0] xf, yf;
	always_comb begin
		if (!z_q[TRIG_W-1]) begin
			xf = x_q - ys;
			yf = y_q + xs;
		end else begin
			xf = x_q + ys;
			yf = y_q - xs;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			cos_o <= neg_q ? -xf : xf;
			sin_o <= neg_q ? -yf : yf;
		end
	end
endmodule
`default_nettype wire

// ----- sv/ejq_qmul.sv -----
// Quaternion times axis rotation, one product per cycle, round and saturate.
`timescale 1ns / 1ps
`default_nettype none
module ejq_qmul import ejq_pkg::*; #(
	parameter int QUAT_FRAC_BITS = 30
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [1:0]              axis,
	input  wire quat_t                   q,
	input  wire logic signed [TRIG_W-1:0] c,
	input  wire logic signed [TRIG_W-1:0] s,
	output logic                         done,
	output quat_t                        res
);
	localparam logic signed [67:0] RND = 68'sd1 <<< (QUAT_FRAC_BITS - 1);
	localparam logic signed [67:0] SMAX = 68'sd2147483647;
	localparam logic signed [67:0] SMIN = -68'sd2147483648;

	logic busy_q, vld_s1, done_q;
	logic [2:0] k_q, k_s1;
	logic neg_s1;
	logic [1:0] axis_q;
	logic signed [65:0] prod_s1, acc_q;
	term_t tm;
	logic signed [31:0] qop;
	logic signed [TRIG_W-1:0] top;
	logic signed [67:0] sum, shd;
	logic [31:0] sat;

	assign tm = term_sel(axis_q, k_q);
	assign qop = $signed(q[tm.qi]);
	assign top = tm.use_s ? s : c;
	assign sum = (neg_s1 ? 68'(acc_q) - 68'(prod_s1) : 68'(acc_q) + 68'(prod_s1)) + RND;
	assign shd = sum >>> QUAT_FRAC_BITS;
	assign sat = (shd > SMAX) ? 32'h7FFF_FFFF : (shd < SMIN) ? 32'h8000_0000 : shd[31:0];
	// done follows the write of the last part
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
			k_q <= '0;
		end else begin
			vld_s1 <= busy_q;
			done_q <= vld_s1 && (k_s1 == 3'd7);
			if (start) begin
				busy_q <= 1'b1;
				k_q <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 3'd1;
				if (k_q == 3'd7) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) axis_q <= axis;
		prod_s1 <= qop * top;
		k_s1 <= k_q;
		neg_s1 <= tm.neg;
		if (vld_s1) begin
			if (!k_s1[0]) acc_q <= prod_s1;
			else res[k_s1[2:1]] <= sat;
		end
	end
endmodule
`default_nettype wire

// ----- sv/euler_channels_to_joint_quaternion.sv -----
// Joint pose builder: channel beats in, translation and quaternion out.
// Position, unused and no-channel beats are taken in idle; a last or no-channel beat then loads the output in ST_EMIT.
// Rotation beats pass through the serial modulo, the 42-bit serial divide by 720, a fold step,
// min(TRIG_ITERATIONS,31) CORDIC iterations and the product sequencer.
// One beat is worked at a time; the output register holds a result while the next is taken.
// arst_n clears translation to zero, rotation to identity, and the output to empty.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module euler_channels_to_joint_quaternion import ejq_pkg::*; #(
	parameter int VALUE_FRAC_BITS = 16,
	parameter int QUAT_FRAC_BITS = 30,
	parameter int TRIG_ITERATIONS = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         channel_kind,
	input  wire logic signed [31:0] channel_value,
	input  wire logic               last_channel,
	input  wire logic               is_root,
	input  wire logic signed [31:0] offset_x,
	input  wire logic signed [31:0] offset_y,
	input  wire logic signed [31:0] offset_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      trans_x,
	output logic signed [31:0]      trans_y,
	output logic signed [31:0]      trans_z,
	output logic signed [31:0]      quat_w,
	output logic signed [31:0]      quat_x,
	output logic signed [31:0]      quat_y,
	output logic signed [31:0]      quat_z
);
	localparam logic [31:0] Q_ONE = 32'(64'd1 << QUAT_FRAC_BITS);
	localparam quat_t Q_IDENT = {32'd0, 32'd0, 32'd0, Q_ONE};

	state_t state_q, state_d;
	logic [2:0][31:0] trans_q, off_q;
	quat_t quat_q;
	logic last_q, root_q;
	logic [1:0] axis_q;
	logic ov_q;

	logic accept, is_rot, emit_load, trig_done, qm_done;
	logic signed [TRIG_W-1:0] cs, sn;
	quat_t qm_res;

	assign accept = in_valid && in_ready;
	assign is_rot = (channel_kind == KIND_ROT_X) || (channel_kind == KIND_ROT_Y) ||
		(channel_kind == KIND_ROT_Z);

	ejq_trig #(
		.VALUE_FRAC_BITS(VALUE_FRAC_BITS),
		.QUAT_FRAC_BITS(QUAT_FRAC_BITS),
		.TRIG_ITERATIONS(TRIG_ITERATIONS)
	) u_trig (
		.clk(clk), .arst_n(arst_n), .start(accept && is_rot), .deg(channel_value),
		.done(trig_done), .cos_o(cs), .sin_o(sn)
	);

	ejq_qmul #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_qmul (
		.clk(clk), .arst_n(arst_n), .start(trig_done), .axis(axis_q), .q(quat_q),
		.c(cs), .s(sn), .done(qm_done), .res(qm_res)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_rot) state_d = ST_TRIG;
					else if (last_channel || channel_kind == KIND_NONE) state_d = ST_EMIT;
				end
			end
			ST_TRIG: if (trig_done) state_d = ST_QMUL;
			ST_QMUL: if (qm_done) state_d = last_q ? ST_EMIT : ST_IDLE;
			ST_EMIT: if (emit_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		emit_load = (state_q == ST_EMIT) && (!ov_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q <= 1'b0;
			trans_q <= '0;
			quat_q <= Q_IDENT;
		end else begin
			state_q <= state_d;
			if (emit_load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (accept) begin
				if (channel_kind == KIND_POS_X || channel_kind == KIND_POS_Y ||
					channel_kind == KIND_POS_Z) begin
					trans_q[channel_kind[1:0]] <= channel_value;
				end else if (channel_kind == KIND_NONE) begin
					trans_q <= '0;
					quat_q <= Q_IDENT;
				end
			end
			if (qm_done) quat_q <= qm_res;
			if (emit_load) begin
				trans_q <= '0;
				quat_q <= Q_IDENT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= last_channel;
			root_q <= is_root;
			off_q <= {offset_z, offset_y, offset_x};
			axis_q <= 2'(channel_kind - KIND_ROT_X);
		end
		if (emit_load) begin
			trans_x <= root_q ? trans_q[0] : off_q[0];
			trans_y <= root_q ? trans_q[1] : off_q[1];
			trans_z <= root_q ? trans_q[2] : off_q[2];
			quat_w <= quat_q[0];
			quat_x <= quat_q[1];
			quat_y <= quat_q[2];
			quat_z <= quat_q[3];
		end
	end

	assign out_valid = ov_q;

	`EJQ_ASSERT(a_trig_done_state, trig_done |-> (state_q == ST_TRIG))
	`EJQ_ASSERT(a_qm_done_state, qm_done |-> (state_q == ST_QMUL))
	`EJQ_ASSERT_NEXT(a_emit_clears, emit_load, (quat_q == Q_IDENT) && (trans_q == '0) && ov_q)
endmodule
`default_nettype wire

// ----- tb/euler_channels_to_joint_quaternion_tb.sv -----
// Testbench for the joint pose builder: scoreboard with a fixed-point pose predictor.
`timescale 1ns / 1ps
`default_nettype none
module euler_channels_to_joint_quaternion_tb;
	import ejq_pkg::*;

	typedef struct {
		logic [2:0] kind;
		logic signed [31:0] value;
		logic last;
		logic root;
		logic signed [31:0] ox, oy, oz;
	} beat_t;

	typedef struct {
		logic signed [31:0] t [3];
		logic signed [31:0] q [4];
	} pose_t;

	localparam longint ONE_Q = 64'sd1 << 30;

	class pose_scoreboard;
		logic signed [31:0] tr [3];
		logic signed [31:0] rot [4];
		pose_t poses [$];
		int errors;

		function void clear_pose();
			tr = '{0, 0, 0};
			rot = '{ONE_Q[31:0], 0, 0, 0};
		endfunction

		function longint fshift(longint v, int s);
			return v >>> s;
		endfunction

		function logic signed [31:0] round_pair(longint a, longint b, longint c, longint d);
			longint s;
			s = fshift(a * b + c * d + (64'sd1 <<< 29), 30);
			if (s > 64'sd2147483647) return 32'sh7fffffff;
			if (s < -64'sd2147483648) return 32'sh80000000;
			return s[31:0];
		endfunction

		function void half_trig(longint deg, output longint cs, output longint sn);
			longint m, t, p, z, x, y, nx;
			bit neg;
			m = 64'sd720 <<< 16;
			t = deg % m;
			neg = 0;
			if (t < 0) t += m;
			p = (t <<< 16) / 720;
			if (p < 64'sh40000000) z = p;
			else if (p >= 64'shC0000000) z = p - 64'sh100000000;
			else begin
				z = p - 64'sh80000000;
				neg = 1;
			end
			x = 652032874;
			y = 0;
			for (int i = 0; i < 24; i++) begin
				if (z >= 0) begin
					nx = x - fshift(y, i);
					y = y + fshift(x, i);
					z -= longint'(ATAN_TURNS[i]);
				end else begin
					nx = x + fshift(y, i);
					y = y - fshift(x, i);
					z += longint'(ATAN_TURNS[i]);
				end
				x = nx;
			end
			if (neg) begin
				x = -x;
				y = -y;
			end
			cs = x;
			sn = y;
		endfunction

		function void rotate(int axis, longint deg);
			longint c, s, w, x, y, z;
			w = rot[0]; x = rot[1]; y = rot[2]; z = rot[3];
			half_trig(deg, c, s);
			if (axis == 0) begin
				rot[0] = round_pair(w, c, -x, s);
				rot[1] = round_pair(w, s, x, c);
				rot[2] = round_pair(y, c, z, s);
				rot[3] = round_pair(z, c, -y, s);
			end else if (axis == 1) begin
				rot[0] = round_pair(w, c, -y, s);
				rot[1] = round_pair(x, c, -z, s);
				rot[2] = round_pair(w, s, y, c);
				rot[3] = round_pair(z, c, x, s);
			end else begin
				rot[0] = round_pair(w, c, -z, s);
				rot[1] = round_pair(x, c, y, s);
				rot[2] = round_pair(y, c, -x, s);
				rot[3] = round_pair(w, s, z, c);
			end
		endfunction

		function void note_beat(beat_t b);
			pose_t p;
			bit last;
			last = b.last;
			if (b.kind == KIND_NONE) begin
				clear_pose();
				last = 1;
			end else if (b.kind <= KIND_POS_Z) tr[b.kind] = b.value;
			else if (b.kind <= KIND_ROT_Z) rotate(b.kind - KIND_ROT_X, b.value);
			if (!last) return;
			p.t[0] = b.root ? tr[0] : b.ox;
			p.t[1] = b.root ? tr[1] : b.oy;
			p.t[2] = b.root ? tr[2] : b.oz;
			for (int i = 0; i < 4; i++) p.q[i] = rot[i];
			poses.push_back(p);
			clear_pose();
		endfunction

		function void check_pose(pose_t got);
			pose_t e;
			if (poses.size() == 0) begin
				report("unexpected pose", 0, 0);
				return;
			end
			e = poses.pop_front();
			for (int i = 0; i < 3; i++)
				if (got.t[i] !== e.t[i]) report("translation", got.t[i], e.t[i]);
			for (int i = 0; i < 4; i++)
				if (got.q[i] !== e.q[i]) report("quaternion", got.q[i], e.q[i]);
		endfunction

		function void report(string what, logic [31:0] got, logic [31:0] exp);
			errors++;
			if (errors <= 50) $display("MISMATCH %s: got %h exp %h", what, got, exp);
		endfunction
	endclass

	logic clk, arst_n, in_valid, in_ready, last_channel, is_root, out_valid, out_ready;
	logic [2:0] channel_kind;
	logic signed [31:0] channel_value, offset_x, offset_y, offset_z;
	logic signed [31:0] trans_x, trans_y, trans_z, quat_w, quat_x, quat_y, quat_z;

	pose_scoreboard sb;
	bit stim_done, hold_off;
	longint cycles;

	euler_channels_to_joint_quaternion dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
			3: return ($signed($urandom_range(0, 1440)) - 720) <<< 16;
			default: return $urandom;
		endcase
	endfunction

	task automatic send(beat_t b);
		@(negedge clk);
		in_valid <= 1;
		channel_kind <= b.kind;
		channel_value <= b.value;
		last_channel <= b.last;
		is_root <= b.root;
		offset_x <= b.ox;
		offset_y <= b.oy;
		offset_z <= b.oz;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(b);
	endtask

	task automatic send_idle();
		@(negedge clk);
		in_valid <= 0;
		channel_kind <= 3'($urandom);
		channel_value <= $urandom;
	endtask

	function automatic beat_t mk(logic [2:0] k, logic signed [31:0] v, logic l, logic r);
		beat_t b;
		b.kind = k;
		b.value = v;
		b.last = l;
		b.root = r;
		b.ox = $urandom;
		b.oy = $urandom;
		b.oz = $urandom;
		return b;
	endfunction

	task automatic send_joint();
		int n;
		bit root;
		n = $urandom_range(0, 6);
		root = 1'($urandom_range(0, 1));
		if (n == 0) send(mk(KIND_NONE, rand_value(), 1'($urandom), root));
		for (int i = 0; i < n; i++) begin
			logic [2:0] k;
			k = $urandom_range(0, 15) == 0 ? 3'd7 : 3'($urandom_range(0, 5));
			send(mk(k, rand_value(), i == n - 1, root));
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 6)) send_idle();
		end
	endtask

	initial begin
		beat_t b;
		sb = new();
		sb.clear_pose();
		arst_n = 0;
		in_valid = 0;
		channel_kind = 0;
		channel_value = 0;
		last_channel = 0;
		is_root = 0;
		offset_x = 0;
		offset_y = 0;
		offset_z = 0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1;
		// directed: extremes, every kind, no-channel joint, unused kind
		send(mk(KIND_POS_X, 32'sh7fffffff, 0, 1));
		send(mk(KIND_POS_Y, 32'sh80000000, 0, 1));
		send(mk(KIND_POS_Z, -1, 0, 1));
		send(mk(KIND_ROT_X, 90 <<< 16, 0, 1));
		send(mk(KIND_ROT_Y, -(45 <<< 16), 0, 1));
		send(mk(KIND_ROT_Z, 32'sh7fffffff, 1, 1));
		send(mk(KIND_ROT_X, 32'sh80000000, 0, 0));
		send(mk(KIND_ROT_Y, 360 <<< 16, 0, 0));
		send(mk(KIND_ROT_Z, 180 <<< 16, 1, 0));
		send(mk(KIND_ROT_X, 720 <<< 16, 1, 1));
		send(mk(KIND_ROT_Y, 0, 1, 1));
		send(mk(KIND_POS_X, 5, 0, 1));
		send(mk(KIND_NONE, 32'sh7fffffff, 0, 1));
		send(mk(KIND_NONE, 0, 1, 0));
		send(mk(3'd7, 32'sh12345678, 0, 1));
		send(mk(3'd7, -1, 1, 1));
		b = mk(KIND_POS_Z, 32'sh7fffffff, 1, 0);
		b.ox = 32'sh7fffffff;
		b.oy = 32'sh80000000;
		b.oz = -1;
		send(b);
		send(mk(KIND_ROT_Z, 270 <<< 16, 0, 1));
		send(mk(KIND_ROT_X, 1, 1, 1));
		for (int j = 0; j < 300; j++) begin
			if ($urandom_range(0, 9) == 0)
				send(mk(3'($urandom), $urandom, 1'($urandom), 1'($urandom)));
			else send_joint();
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 20)) send_idle();
		end
		send_idle();
		stim_done = 1;
	end

	// receiver: own stall pattern plus one long hold-off
	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) out_ready <= 0;
			else if (cycles < 30000) out_ready <= 1;
			else out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		hold_off = 0;
		repeat (6000) @(posedge clk);
		hold_off = 1;
		repeat (2000) @(posedge clk);
		hold_off = 0;
	end

	always @(posedge clk) begin
		pose_t got;
		if (arst_n && out_valid && out_ready) begin
			got.t = '{trans_x, trans_y, trans_z};
			got.q = '{quat_w, quat_x, quat_y, quat_z};
			sb.check_pose(got);
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 2000000) begin
				$display("euler_channels_to_joint_quaternion_tb failed");
				$finish;
			end
		end
	end

	initial begin
		wait (stim_done);
		while (sb.poses.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.poses.size() == 0)
			$display("euler_channels_to_joint_quaternion_tb passed");
		else
			$display("euler_channels_to_joint_quaternion_tb failed");
		$finish;
	end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+sv
sv/ejq_pkg.sv
sv/ejq_trig.sv
sv/ejq_qmul.sv
sv/euler_channels_to_joint_quaternion.sv
tb/euler_channels_to_joint_quaternion_tb.sv
